// File: hw/rtl/sem_pkg.sv
// shared types and constants of the rgb sobel edge magnitude unit
package sem_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 16;
   localparam int ROW_BITS    = HEIGHT_BITS + 1;
   localparam int PIX_BITS    = 24;
   localparam int LINE_BITS   = 2 * PIX_BITS;
   localparam int CHAN_BITS   = 8;
   localparam int GRAD_BITS   = 12;
   localparam int SUM_BITS    = 21;
   localparam int ADDR_BITS   = 3;
   localparam int DATA_BITS   = 32;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
   localparam logic [WIDTH_BITS-1:0]  WIDTH_LIMIT  = WIDTH_BITS'(MAX_WIDTH);
   localparam logic [SUM_BITS-1:0]    CLAMP_LIMIT  = SUM_BITS'(65280);
   localparam logic [CHAN_BITS-1:0]   EDGE_MAX     = CHAN_BITS'(255);

   // item kinds
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   // register index (byte address bit 2)
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [CHAN_BITS-1:0] red_in;
      logic [CHAN_BITS-1:0] green_in;
      logic [CHAN_BITS-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]   red_edge;
      logic [CHAN_BITS-1:0]   green_edge;
      logic [CHAN_BITS-1:0]   blue_edge;
      logic [HEIGHT_BITS-1:0] out_row;
      logic [COL_BITS-1:0]    out_col;
      logic                   frame_last;
   } rsp_type;

   // masked 3x3 window, index row*3+col, plus result position
   typedef struct packed {
      logic [8:0][PIX_BITS-1:0] win;
      logic [HEIGHT_BITS-1:0]   row;
      logic [COL_BITS-1:0]      col;
      logic                     last;
   } job_type;

endpackage

// File: hw/rtl/sem_ram.sv
// generic single write port ram with registered read
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: hw/rtl/sem_front.sv
// front end: position tracking, line stores, window and masking
module sem_front import sem_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  logic [WIDTH_BITS-1:0]  eff_width,
   input  logic [HEIGHT_BITS-1:0] eff_height,
   input  logic                   accept,
   input  req_type                req,
   output logic                   idle,
   output logic                   job_push,
   output job_type                job
);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC} state_type;

   state_type                 state_ff, state_in;
   logic                      mode_ff, mode_in;
   logic [PIX_BITS-1:0]       pix_ff, pix_in;
   logic [COL_BITS-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0]       row_ff, row_in;
   logic [WIDTH_BITS-1:0]     pending_ff, pending_in;
   logic                      draining_ff, draining_in;
   logic [2:0][2:0][PIX_BITS-1:0] win_ff, win_in, shifted;

   logic                      wr_en;
   logic [LINE_BITS-1:0]      rd_data;
   logic [PIX_BITS-1:0]       top, mid, bot;
   logic signed [ROW_BITS+1:0] cr, r;
   logic [COL_BITS-1:0]       cc;
   logic signed [WIDTH_BITS+1:0] c;
   logic [2:0]                row_ok, col_ok;
   logic                      made;
   logic [WIDTH_BITS-1:0]     col_next, pend_dec;
   logic                      wrap;
   logic [COL_BITS-1:0]       adv_col;
   logic [ROW_BITS-1:0]       adv_row;

   sem_ram #(.WIDTH(LINE_BITS), .DEPTH(MAX_WIDTH)) u_lines (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (col_ff),
      .wr_data ({mid, bot}),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   assign top  = rd_data[LINE_BITS-1:PIX_BITS];
   assign mid  = rd_data[PIX_BITS-1:0];
   assign bot  = (mode_ff == MODE_DRAIN) ? '0 : pix_ff;
   assign idle = (state_ff == S_IDLE);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shifted[i][0] = win_ff[i][1];
         shifted[i][1] = win_ff[i][2];
      end
      shifted[0][2] = top;
      shifted[1][2] = mid;
      shifted[2][2] = bot;
   end

   // centre of the result and its frame mask
   always_comb begin
      if (col_ff != '0) begin
         cr = $signed({2'b00, row_ff}) - (ROW_BITS+2)'(1);
         cc = col_ff - COL_BITS'(1);
      end else begin
         cr = $signed({2'b00, row_ff}) - (ROW_BITS+2)'(2);
         cc = COL_BITS'(eff_width - WIDTH_BITS'(1));
      end
      made = !cr[ROW_BITS+1];
      for (int i = 0; i < 3; i++) begin
         r = cr + (ROW_BITS+2)'(i) - (ROW_BITS+2)'(1);
         row_ok[i] = !r[ROW_BITS+1]
                     && (r < $signed({3'b000, eff_height}));
         c = $signed({2'b00, 1'b0, cc}) + (WIDTH_BITS+2)'(i) - (WIDTH_BITS+2)'(1);
         col_ok[i] = !c[WIDTH_BITS+1] && (c < $signed({2'b00, eff_width}));
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            job.win[i*3+j] = (row_ok[i] && col_ok[j]) ? shifted[i][j] : '0;
         end
      end
      job.row  = cr[HEIGHT_BITS-1:0];
      job.col  = cc;
      job.last = (cr == $signed({3'b000, eff_height}) - (ROW_BITS+2)'(1))
                 && ({1'b0, cc} == eff_width - WIDTH_BITS'(1));
   end

   always_comb begin
      col_next = {1'b0, col_ff} + WIDTH_BITS'(1);
      wrap     = (col_next >= eff_width);
      adv_col  = wrap ? '0 : col_next[COL_BITS-1:0];
      adv_row  = wrap ? row_ff + ROW_BITS'(1) : row_ff;
      pend_dec = (pending_ff != '0) ? pending_ff - WIDTH_BITS'(1) : pending_ff;
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      pix_in      = pix_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      pending_in  = pending_ff;
      draining_in = draining_ff;
      win_in      = win_ff;
      wr_en       = 1'b0;
      job_push    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = req.mode;
               pix_in  = {req.red_in, req.green_in, req.blue_in};
               if ((req.mode == MODE_PIXEL && !draining_ff)
                   || (req.mode == MODE_DRAIN && draining_ff)) begin
                  state_in = S_EXEC;
               end
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            wr_en  = 1'b1;
            win_in = shifted;
            col_in = adv_col;
            row_in = adv_row;
            if (mode_ff == MODE_PIXEL) begin
               job_push = made;
               state_in = S_IDLE;
               if (adv_row >= {1'b0, eff_height}) begin
                  draining_in = 1'b1;
                  pending_in  = (eff_height >= HEIGHT_BITS'(2))
                                ? eff_width + WIDTH_BITS'(1) : eff_width;
               end
            end else if (!made) begin
               // top of frame: shift once more before a result appears
               state_in = S_READ;
            end else begin
               job_push   = 1'b1;
               state_in   = S_IDLE;
               pending_in = pend_dec;
               if (pend_dec == '0) begin
                  col_in      = '0;
                  row_in      = '0;
                  draining_in = 1'b0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (restart) begin
         col_in      = '0;
         row_in      = '0;
         pending_in  = '0;
         draining_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         col_ff      <= '0;
         row_ff      <= '0;
         pending_ff  <= '0;
         draining_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         pending_ff  <= pending_in;
         draining_ff <= draining_in;
      end
      mode_ff <= mode_in;
      pix_ff  <= pix_in;
      win_ff  <= win_in;
   end

endmodule

// File: hw/rtl/sem_job_queue.sv
// two entry queue of window jobs between front and back
module sem_job_queue import sem_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output logic    valid,
   output logic    full,
   output job_type pop_data
);

   job_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign valid    = (count_ff != 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_data = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/sem_back.sv
// back end: gradients, squares, bitwise square root, rounding, result queue
module sem_back import sem_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp
);

   typedef enum logic [1:0] {B_IDLE, B_SQUARE, B_ROOT, B_ROUND} state_type;

   state_type state_ff, state_in;
   logic signed [GRAD_BITS-1:0] gx_ff [3], gx_in [3];
   logic signed [GRAD_BITS-1:0] gy_ff [3], gy_in [3];
   logic [SUM_BITS-1:0]  sum_ff [3], sum_in [3];
   logic [CHAN_BITS-1:0] q_ff [3], q_in [3];
   logic [2:0]           bit_ff, bit_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic                 last_ff, last_in;
   logic [CHAN_BITS-1:0] edge_val [3];
   logic [CHAN_BITS-1:0] t, mask;
   logic [2*CHAN_BITS-1:0] tt;
   logic [2*CHAN_BITS:0] qq;
   logic signed [2*GRAD_BITS-1:0] sx, sy;

   rsp_type    ent_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       rsp_push, rsp_pop;

   function automatic logic signed [GRAD_BITS-1:0] pix(input job_type j, input int k,
                                                       input int ch);
      return $signed({4'b0000, j.win[k][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS]});
   endfunction

   assign mask = CHAN_BITS'(1) << bit_ff;

   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      last_in  = last_ff;
      job_pop  = 1'b0;
      rsp_push = 1'b0;
      t  = '0;
      tt = '0;
      qq = '0;
      sx = '0;
      sy = '0;
      for (int ch = 0; ch < 3; ch++) begin
         gx_in[ch]    = gx_ff[ch];
         gy_in[ch]    = gy_ff[ch];
         sum_in[ch]   = sum_ff[ch];
         q_in[ch]     = q_ff[ch];
         edge_val[ch] = '0;
      end
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid && count_ff != 2'd2) begin
               job_pop  = 1'b1;
               row_in   = job.row;
               col_in   = job.col;
               last_in  = job.last;
               state_in = B_SQUARE;
               for (int ch = 0; ch < 3; ch++) begin
                  gx_in[ch] = (pix(job, 2, ch) + (pix(job, 5, ch) <<< 1) + pix(job, 8, ch))
                            - (pix(job, 0, ch) + (pix(job, 3, ch) <<< 1) + pix(job, 6, ch));
                  gy_in[ch] = (pix(job, 6, ch) + (pix(job, 7, ch) <<< 1) + pix(job, 8, ch))
                            - (pix(job, 0, ch) + (pix(job, 1, ch) <<< 1) + pix(job, 2, ch));
               end
            end
         end
         B_SQUARE: begin
            for (int ch = 0; ch < 3; ch++) begin
               sx = gx_ff[ch] * gx_ff[ch];
               sy = gy_ff[ch] * gy_ff[ch];
               sum_in[ch] = SUM_BITS'(sx) + SUM_BITS'(sy);
               q_in[ch]   = '0;
            end
            bit_in   = 3'd7;
            state_in = B_ROOT;
         end
         B_ROOT: begin
            // one result bit per cycle, all channels side by side
            for (int ch = 0; ch < 3; ch++) begin
               t  = q_ff[ch] | mask;
               tt = {8'h00, t} * {8'h00, t};
               if ({5'b00000, tt} <= sum_ff[ch]) begin
                  q_in[ch] = t;
               end
            end
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = B_ROUND;
            end
         end
         B_ROUND: begin
            for (int ch = 0; ch < 3; ch++) begin
               qq = {9'h000, q_ff[ch]} * {9'h000, q_ff[ch]} + {9'h000, q_ff[ch]};
               if (sum_ff[ch] > CLAMP_LIMIT) begin
                  edge_val[ch] = EDGE_MAX;
               end else if (sum_ff[ch] > {4'h0, qq}) begin
                  edge_val[ch] = q_ff[ch] + CHAN_BITS'(1);
               end else begin
                  edge_val[ch] = q_ff[ch];
               end
            end
            rsp_push = 1'b1;
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign empty   = (count_ff == 2'd0);
   assign rsp_pop = pop && !empty;
   assign rsp     = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (rsp_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (rsp_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(rsp_push) - 2'(rsp_pop);
      end
      for (int ch = 0; ch < 3; ch++) begin
         gx_ff[ch]  <= gx_in[ch];
         gy_ff[ch]  <= gy_in[ch];
         sum_ff[ch] <= sum_in[ch];
         q_ff[ch]   <= q_in[ch];
      end
      bit_ff  <= bit_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      last_ff <= last_in;
      if (rsp_push) begin
         ent_ff[wr_ptr_ff] <= '{red_edge:   edge_val[0],
                                green_edge: edge_val[1],
                                blue_edge:  edge_val[2],
                                out_row:    row_ff,
                                out_col:    col_ff,
                                frame_last: last_ff};
      end
   end

endmodule

// File: hw/rtl/sobel_edge_magnitude_rgb_unit.sv
// top level of the streaming rgb 3x3 sobel edge magnitude unit
//
//   channel   ports                           direction  transfer when
//   pixels    push full req_data              in         push && !full
//   results   pop empty rsp_data              out        pop && !empty
//   csr       psel penable pwrite paddr       in         psel && penable && pwrite
//             pwdata prdata pready
//
// a pixel item passes the front end as line store read, then window
// shift and write back; a drain at the top of a one-row frame shifts again.
// the back end forms gradients, squares, a bit-per-cycle square root and
// rounding; it takes no new job while busy or while its result queue is
// full. synchronous reset, no clearing pass: line store entries that were
// never written only feed window rows outside the frame, which are masked.
// full rises while the front end works or the job queue is full
module sobel_edge_magnitude_rgb_unit import sem_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  req_type              req_data,
   input  logic                 pop,
   output logic                 empty,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;
   logic [WIDTH_BITS-1:0]  eff_width;
   logic [HEIGHT_BITS-1:0] eff_height;
   logic                   csr_write;
   logic                   front_idle, accept;
   logic                   job_push, job_pop, job_valid, job_full;
   job_type                job_in, job_out;

   // register file: any write restarts the frame
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_HEIGHT) ? DATA_BITS'(height_ff)
                                               : DATA_BITS'(width_ff);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_WIDTH:  width_in  = pwdata[WIDTH_BITS-1:0];
            REG_HEIGHT: height_in = pwdata[HEIGHT_BITS-1:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // zero sizes act as one, widths beyond the line store clip to it
   always_comb begin
      if (width_ff == '0) begin
         eff_width = WIDTH_BITS'(1);
      end else if (width_ff > WIDTH_LIMIT) begin
         eff_width = WIDTH_LIMIT;
      end else begin
         eff_width = width_ff;
      end
      eff_height = (height_ff == '0) ? HEIGHT_BITS'(1) : height_ff;
   end

   // front end takes an item only when idle with room for one job
   assign full   = !front_idle || job_full;
   assign accept = push && !full;

   sem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .accept     (accept),
      .req        (req_data),
      .idle       (front_idle),
      .job_push   (job_push),
      .job        (job_in)
   );

   sem_job_queue u_jobs (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .valid     (job_valid),
      .full      (job_full),
      .pop_data  (job_out)
   );

   sem_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job_out),
      .job_pop   (job_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp_data)
   );

endmodule

// File: test/sobel_edge_magnitude_rgb_unit_tb.sv
// self-checking testbench of the rgb sobel edge magnitude unit
module sobel_edge_magnitude_rgb_unit_tb;
   import sem_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 4000;  // cycles with no transfer before giving up
   localparam int SETTLE_TICKS = 40;    // front end plus back end square root, with margin
   localparam int RANDOM_ITEMS = 500;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   req_type              req_data = '0;
   logic                 pop = 1'b0;
   logic                 empty;
   rsp_type              rsp_data;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   sobel_edge_magnitude_rgb_unit dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .pop(pop), .empty(empty), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   // shadow copy of the block state
   logic [WIDTH_BITS-1:0]  width_reg;
   logic [HEIGHT_BITS-1:0] height_reg;
   logic [PIX_BITS-1:0]    older_row [MAX_WIDTH];
   logic [PIX_BITS-1:0]    newer_row [MAX_WIDTH];
   logic [PIX_BITS-1:0]    win [3][3];
   int                     next_col;
   int                     next_row;
   int                     owed_results;
   bit                     frame_draining;

   rsp_type edge_results_due [$];

   int idle_pct  = 0;    // sender gap probability, percent
   int stall_pct = 0;    // receiver stall probability, percent
   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int frames_done = 0;
   int idle_cycles = 0;

   function automatic int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > WIDTH_LIMIT) return MAX_WIDTH;
      return int'(width_reg);
   endfunction

   function automatic int eff_height();
      return (height_reg == 0) ? 1 : int'(height_reg);
   endfunction

   // exact round(sqrt(s)) clamped to 8 bits
   function automatic logic [7:0] sobel_mag(int gx, int gy);
      int unsigned s, q, t;
      s = gx * gx + gy * gy;
      q = 0;
      for (int b = 11; b >= 0; b--) begin
         t = q | (1 << b);
         if (t * t <= s) q = t;
      end
      if (s > q * q + q) q++;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   task automatic restart_frame();
      next_col = 0;
      next_row = 0;
      owed_results = 0;
      frame_draining = 0;
   endtask

   task automatic shift_column(input logic [PIX_BITS-1:0] top, mid, bot,
                               output bit made, output rsp_type r);
      int w, h, cr, cc, gx, gy, rr, c, v, sh;
      logic [7:0] mags [3];
      w = eff_width();
      h = eff_height();
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = bot;
      made = 0;
      r = '0;
      if (next_col >= 1) begin
         cr = next_row - 1;
         cc = next_col - 1;
      end else begin
         cr = next_row - 2;
         cc = w - 1;
      end
      if (cr < 0) return;
      for (int ch = 0; ch < 3; ch++) begin
         gx = 0;
         gy = 0;
         sh = 16 - 8 * ch;
         for (int i = 0; i < 3; i++) begin
            rr = cr - 1 + i;
            if (rr < 0 || rr >= h) continue;
            for (int j = 0; j < 3; j++) begin
               c = cc - 1 + j;
               if (c < 0 || c >= w) continue;
               v = int'((win[i][j] >> sh) & 24'hFF);
               // kx = column weight times row weight, ky the transpose
               gx += (j - 1) * ((i == 1) ? 2 : 1) * v;
               gy += (i - 1) * ((j == 1) ? 2 : 1) * v;
            end
         end
         mags[ch] = sobel_mag(gx, gy);
      end
      r.red_edge   = mags[0];
      r.green_edge = mags[1];
      r.blue_edge  = mags[2];
      r.out_row    = cr[HEIGHT_BITS-1:0];
      r.out_col    = cc[COL_BITS-1:0];
      r.frame_last = (cr == h - 1 && cc == w - 1);
      made = 1;
   endtask

   task automatic advance_position();
      next_col++;
      if (next_col >= eff_width()) begin
         next_col = 0;
         next_row++;
      end
   endtask

   // run one accepted item through the shadow state
   task automatic predict_item(input req_type it);
      bit made;
      rsp_type r;
      int col;
      logic [PIX_BITS-1:0] mid;
      made = 0;
      if (it.mode == MODE_PIXEL) begin
         if (frame_draining) return;
         col = next_col % MAX_WIDTH;
         mid = newer_row[col];
         shift_column(older_row[col], mid, {it.red_in, it.green_in, it.blue_in}, made, r);
         older_row[col] = mid;
         newer_row[col] = {it.red_in, it.green_in, it.blue_in};
         advance_position();
         if (next_row >= eff_height()) begin
            frame_draining = 1;
            owed_results = (eff_height() >= 2) ? eff_width() + 1 : eff_width();
         end
      end else begin
         if (!frame_draining) return;
         // one-row frames may need extra internal shifts before a result
         for (int tries = 0; tries < 3 && !made; tries++) begin
            col = next_col % MAX_WIDTH;
            mid = newer_row[col];
            shift_column(older_row[col], mid, '0, made, r);
            older_row[col] = mid;
            newer_row[col] = '0;
            advance_position();
         end
         if (made && owed_results > 0) owed_results--;
         if (owed_results == 0) begin
            restart_frame();
            frames_done++;
         end
      end
      if (made) edge_results_due.push_back(r);
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   // result side: random stalls, compare against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (pop && !empty) begin
            if (edge_results_due.size() == 0) begin
               report_mismatch("unexpected result, row", rsp_data.out_row, -1);
            end else begin
               want = edge_results_due.pop_front();
               results_checked++;
               if (rsp_data.red_edge !== want.red_edge)
                  report_mismatch("red_edge", rsp_data.red_edge, want.red_edge);
               if (rsp_data.green_edge !== want.green_edge)
                  report_mismatch("green_edge", rsp_data.green_edge, want.green_edge);
               if (rsp_data.blue_edge !== want.blue_edge)
                  report_mismatch("blue_edge", rsp_data.blue_edge, want.blue_edge);
               if (rsp_data.out_row !== want.out_row)
                  report_mismatch("out_row", rsp_data.out_row, want.out_row);
               if (rsp_data.out_col !== want.out_col)
                  report_mismatch("out_col", rsp_data.out_col, want.out_col);
               if (rsp_data.frame_last !== want.frame_last)
                  report_mismatch("frame_last", rsp_data.frame_last, want.frame_last);
            end
         end
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty) || (psel && penable))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // send one item, with random sender gaps ahead of it
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
      predict_item(it);
   endtask

   function automatic req_type pixel(logic [7:0] r, g, b);
      req_type it;
      it.mode = MODE_PIXEL;
      it.red_in = r;
      it.green_in = g;
      it.blue_in = b;
      return it;
   endfunction

   function automatic req_type drain_tick();
      req_type it;
      it = {MODE_DRAIN, 24'($urandom)};   // payload bits of a drain are don't care
      return it;
   endfunction

   function automatic req_type random_pixel();
      return pixel(8'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   // wait until the block has nothing in flight
   task automatic wait_quiet();
      @(posedge clock);
      push <= 1'b0;
      while (edge_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic csr_write(input logic regsel, input logic [DATA_BITS-1:0] value);
      wait_quiet();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {regsel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (regsel == REG_WIDTH) width_reg = value[WIDTH_BITS-1:0];
      else height_reg = value[HEIGHT_BITS-1:0];
      restart_frame();
   endtask

   task automatic csr_check(input logic regsel, input int want);
      // leave the bus idle between register transfers
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      penable <= 1'b0;
      paddr <= {regsel, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== DATA_BITS'(want)) report_mismatch("register read", prdata, want);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_frame(input int w, input int h);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_check(REG_WIDTH, w & 'h7FF);
      csr_check(REG_HEIGHT, h & 'hFFFF);
   endtask

   // a whole frame of random pixels, drained; some ignored items mixed in
   task automatic run_frame(input int noise_pct);
      while (!frame_draining) begin
         if ($urandom_range(99) < noise_pct) send_item(drain_tick());
         else send_item(random_pixel());
      end
      while (frame_draining) begin
         if ($urandom_range(99) < noise_pct) send_item(random_pixel());
         else send_item(drain_tick());
      end
   endtask

   task automatic test_reset_values();
      csr_check(REG_WIDTH, 640);
      csr_check(REG_HEIGHT, 480);
   endtask

   // 3x3 frame with channel extremes, plus items that must be ignored
   task automatic test_directed_frame();
      set_frame(3, 3);
      send_item(drain_tick());                 // drain while not draining
      send_item(pixel(8'hFF, 8'h00, 8'hFF));
      send_item(pixel(8'h00, 8'hFF, 8'h00));
      send_item(pixel(8'hFF, 8'hFF, 8'hFF));
      send_item(pixel(8'h00, 8'h00, 8'h00));
      send_item(pixel(8'hFF, 8'h00, 8'h55));
      send_item(pixel(8'hAA, 8'hFF, 8'h00));
      send_item(pixel(8'hFF, 8'hFF, 8'hFF));
      send_item(pixel(8'h00, 8'h00, 8'h00));
      send_item(pixel(8'hFF, 8'hFF, 8'hFF));
      send_item(pixel(8'h12, 8'h34, 8'h56));   // pixel while draining, dropped
      while (frame_draining) send_item(drain_tick());
   endtask

   // one-row frame, width zero acting as one, height zero acting as one
   task automatic test_degenerate_frames();
      set_frame(4, 1);
      run_frame(0);
      set_frame(0, 2);
      run_frame(0);
      set_frame(3, 0);
      run_frame(0);
   endtask

   // width register beyond the line store, partial frames cancelled by a register write
   task automatic test_width_extremes();
      set_frame(2047, 1);
      repeat (20) send_item(random_pixel());
      set_frame(5, 65535);
      repeat (12) send_item(random_pixel());
      set_frame(1024, 2);
      repeat (6) send_item(random_pixel());
   endtask

   task automatic test_random_frames();
      int start, kind;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 79; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 79; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         start = items_sent;
         while (items_sent - start < RANDOM_ITEMS / 4) begin
            kind = $urandom_range(9);
            set_frame($urandom_range(8, 1), $urandom_range(5, 1));
            if (kind == 0) begin
               // broken frame, cut short by the next register write
               repeat ($urandom_range(6, 1)) send_item(random_pixel());
            end else begin
               run_frame(kind < 3 ? 15 : 0);
            end
         end
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) win[i][j] = '0;
      restart_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_directed_frame();
      test_degenerate_frames();
      test_width_extremes();
      test_random_frames();

      wait_quiet();
      $display("covered %0d items, %0d results checked, %0d complete frames",
               items_sent, results_checked, frames_done);
      $display("full frames from 1x1 to 8x5, partial frames up to 1024 wide, "
               , "with sender gaps and receiver stalls");
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
